[rtl/core/tacr_pkg.sv]
// Shared types and constants for the touch average / calibrate / rotate block.
// Used by every module under rtl/core; depends on nothing.
package tacr_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_PRESSURE_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_X_LEVEL_MIN        = 3'd1;
    localparam logic [2:0] REG_X_GAIN             = 3'd2;
    localparam logic [2:0] REG_X_OFFSET           = 3'd3;
    localparam logic [2:0] REG_Y_GAIN             = 3'd4;
    localparam logic [2:0] REG_Y_OFFSET           = 3'd5;
    localparam logic [2:0] REG_ORIENTATION        = 3'd6;

    localparam logic [15:0] GAIN_UNITY = 16'd16384;

    // Orientation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // Queue between front and back
    localparam int QDEPTH = 4;

    typedef enum logic [1:0] {
        PH_Z,
        PH_X,
        PH_Y
    } phase_t;

    typedef enum logic [1:0] {
        OP_NO_TOUCH,
        OP_CAL_X,
        OP_CAL_Y
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] avg;
    } entry_t;

    typedef struct packed {
        logic [15:0] pressure_threshold;
        logic [15:0] x_level_min;
    } front_cfg_t;

    typedef struct packed {
        logic [15:0] x_gain;
        logic [15:0] x_offset;
        logic [15:0] y_gain;
        logic [15:0] y_offset;
        logic [1:0]  orientation;
    } back_cfg_t;

endpackage

[rtl/core/tacr_front.sv]
// Front end: accumulates each sample group, averages it and classifies the group end.
// Depends on tacr_pkg.
module tacr_front #(
    parameter int AVG_SHIFT = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [15:0]         sample,
    input  tacr_pkg::front_cfg_t cfg,
    output logic                push,
    output tacr_pkg::entry_t    push_entry
);

    localparam int GROUP = 1 << AVG_SHIFT;
    localparam int CNT_W = (AVG_SHIFT > 0) ? AVG_SHIFT : 1;
    localparam int SUM_W = 16 + AVG_SHIFT;

    tacr_pkg::phase_t   phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_add;
    logic [15:0]        avg;
    logic               last;

    assign last    = (count_reg == CNT_W'(GROUP - 1));
    assign sum_add = sum_reg + SUM_W'(sample);
    assign avg     = sum_add[AVG_SHIFT +: 16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tacr_pkg::PH_Z;
            count_reg <= '0;
            sum_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            if (accept) begin
                count_reg <= last ? '0 : count_reg + 1'b1;
                sum_reg   <= last ? '0 : sum_add;
            end
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        push             = 1'b0;
        push_entry.op    = tacr_pkg::OP_NO_TOUCH;
        push_entry.avg   = avg;
        if (accept && last) begin
            case (phase_reg)
                tacr_pkg::PH_X: begin
                    push = 1'b1;
                    if (avg <= cfg.x_level_min) begin
                        push_entry.op = tacr_pkg::OP_NO_TOUCH;
                        phase_next    = tacr_pkg::PH_Z;
                    end else begin
                        push_entry.op = tacr_pkg::OP_CAL_X;
                        phase_next    = tacr_pkg::PH_Y;
                    end
                end
                tacr_pkg::PH_Y: begin
                    push          = 1'b1;
                    push_entry.op = tacr_pkg::OP_CAL_Y;
                    phase_next    = tacr_pkg::PH_Z;
                end
                default: begin
                    // pressure group; an unused phase code also lands here
                    if (avg <= cfg.pressure_threshold) begin
                        push          = 1'b1;
                        push_entry.op = tacr_pkg::OP_NO_TOUCH;
                        phase_next    = tacr_pkg::PH_Z;
                    end else begin
                        phase_next    = tacr_pkg::PH_X;
                    end
                end
            endcase
        end
    end

endmodule

[rtl/core/tacr_queue.sv]
// Short FIFO of classified group results between front and back.
// Depends on tacr_pkg.
module tacr_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tacr_pkg::entry_t push_entry,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output tacr_pkg::entry_t head
);

    localparam int PTR_W = $clog2(tacr_pkg::QDEPTH);
    localparam int CNT_W = $clog2(tacr_pkg::QDEPTH + 1);

    tacr_pkg::entry_t mem_reg [tacr_pkg::QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(tacr_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue pop while empty");

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

[rtl/core/tacr_back.sv]
// Back end: gain multiply, offset add, orientation mapping and the result register.
// Depends on tacr_pkg.
module tacr_back #(
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 320
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  tacr_pkg::back_cfg_t cfg,
    input  logic               q_valid,
    input  tacr_pkg::entry_t   q_entry,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_is_touch,
    output logic [15:0]        m_x_pos,
    output logic [15:0]        m_y_pos
);

    localparam logic [15:0] W16 = SCREEN_WIDTH[15:0];
    localparam logic [15:0] H16 = SCREEN_HEIGHT[15:0];

    logic               a_valid_reg;
    tacr_pkg::op_t      a_op_reg;
    logic signed [32:0] a_prod_reg;
    logic               b_valid_reg;
    tacr_pkg::op_t      b_op_reg;
    logic [15:0]        b_cal_reg;
    logic [15:0]        calx_reg;
    logic               m_valid_reg, m_valid_next;
    logic               m_is_touch_reg;
    logic [15:0]        m_x_pos_reg, m_y_pos_reg;

    logic               a_adv, b_adv;
    logic signed [15:0] gain_s;
    logic signed [32:0] prod_w;
    logic [15:0]        offset_sel;
    logic [15:0]        cal_w;
    logic [15:0]        rot_x, rot_y;

    assign b_adv = !m_valid_reg || m_ready;
    assign a_adv = !b_valid_reg || b_adv;
    assign q_pop = q_valid && (!a_valid_reg || a_adv);

    assign gain_s     = (q_entry.op == tacr_pkg::OP_CAL_X) ? $signed(cfg.x_gain)
                                                          : $signed(cfg.y_gain);
    assign prod_w     = gain_s * $signed({1'b0, q_entry.avg});
    assign offset_sel = (a_op_reg == tacr_pkg::OP_CAL_X) ? cfg.x_offset : cfg.y_offset;
    // floor(prod / 2^14) + offset, kept to 16 bits
    assign cal_w      = a_prod_reg[29:14] + offset_sel;

    always_comb begin
        case (cfg.orientation)
            tacr_pkg::ROT_0: begin
                rot_x = calx_reg;
                rot_y = b_cal_reg;
            end
            tacr_pkg::ROT_90: begin
                rot_x = b_cal_reg;
                rot_y = W16 - calx_reg;
            end
            tacr_pkg::ROT_180: begin
                rot_x = W16 - calx_reg;
                rot_y = H16 - b_cal_reg;
            end
            default: begin
                rot_x = H16 - b_cal_reg;
                rot_y = calx_reg;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (b_adv) begin
            m_valid_next = b_valid_reg && (b_op_reg != tacr_pkg::OP_CAL_X);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            calx_reg    <= '0;
        end else begin
            if (!a_valid_reg || a_adv) begin
                a_valid_reg <= q_pop;
            end
            if (a_adv) begin
                b_valid_reg <= a_valid_reg;
            end
            m_valid_reg <= m_valid_next;
            if (b_adv && b_valid_reg && (b_op_reg == tacr_pkg::OP_CAL_X)) begin
                calx_reg <= b_cal_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            a_op_reg   <= q_entry.op;
            a_prod_reg <= prod_w;
        end
        if (a_adv && a_valid_reg) begin
            b_op_reg  <= a_op_reg;
            b_cal_reg <= cal_w;
        end
        if (b_adv && b_valid_reg) begin
            if (b_op_reg == tacr_pkg::OP_CAL_Y) begin
                m_is_touch_reg <= 1'b1;
                m_x_pos_reg    <= rot_x;
                m_y_pos_reg    <= rot_y;
            end else begin
                m_is_touch_reg <= 1'b0;
                m_x_pos_reg    <= '0;
                m_y_pos_reg    <= '0;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_is_touch = m_is_touch_reg;
    assign m_x_pos    = m_x_pos_reg;
    assign m_y_pos    = m_y_pos_reg;

endmodule

[rtl/core/touch_average_calibrate_rotate.sv]
// Top level of the touch sample averager, calibrator and rotator.
// Depends on tacr_pkg, tacr_front, tacr_queue and tacr_back.
//
// Raw 16-bit touch readings enter on the s_ channel, one beat per cycle, in
// groups of 2^AVG_SHIFT: pressure, then X, then Y. Each group is summed and
// shifted down to its average. A pressure or X average at or below its
// threshold yields a "no touch" result (coordinates zero) and restarts at the
// pressure group; otherwise X and Y are calibrated as gain * avg / 2^14 +
// offset (Q2.14 gain, 16-bit wrap) and mapped to the selected orientation.
// One result beat leaves on the m_ channel per finished measurement. The
// block takes one sample every cycle; s_ready drops only when the four-entry
// queue between the accumulator and the calibration pipe is full, which
// happens only while m_ready is held low. After the beat that closes a group,
// its result passes the queue, the multiply register, the offset-add register
// and the output register before m_valid rises; back-pressure can hold it in each.
// Configuration writes on cfg_ are always accepted and must be made while no
// measurement is in flight; unknown indexes are ignored.
module touch_average_calibrate_rotate #(
    parameter int AVG_SHIFT     = 4,
    parameter int SCREEN_WIDTH  = 240,
    parameter int SCREEN_HEIGHT = 320
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_sample,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_touch,
    output logic [15:0] m_x_pos,
    output logic [15:0] m_y_pos,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    tacr_pkg::front_cfg_t front_cfg_reg;
    tacr_pkg::back_cfg_t  back_cfg_reg;

    logic             accept;
    logic             push;
    tacr_pkg::entry_t push_entry;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    tacr_pkg::entry_t q_head;

    // Register file: accept every write beat
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_cfg_reg.pressure_threshold <= '0;
            front_cfg_reg.x_level_min        <= '0;
            back_cfg_reg.x_gain              <= tacr_pkg::GAIN_UNITY;
            back_cfg_reg.x_offset            <= '0;
            back_cfg_reg.y_gain              <= tacr_pkg::GAIN_UNITY;
            back_cfg_reg.y_offset            <= '0;
            back_cfg_reg.orientation         <= tacr_pkg::ROT_0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                tacr_pkg::REG_PRESSURE_THRESHOLD: front_cfg_reg.pressure_threshold <= cfg_data;
                tacr_pkg::REG_X_LEVEL_MIN:        front_cfg_reg.x_level_min        <= cfg_data;
                tacr_pkg::REG_X_GAIN:             back_cfg_reg.x_gain              <= cfg_data;
                tacr_pkg::REG_X_OFFSET:           back_cfg_reg.x_offset            <= cfg_data;
                tacr_pkg::REG_Y_GAIN:             back_cfg_reg.y_gain              <= cfg_data;
                tacr_pkg::REG_Y_OFFSET:           back_cfg_reg.y_offset            <= cfg_data;
                tacr_pkg::REG_ORIENTATION:        back_cfg_reg.orientation         <= cfg_data[1:0];
                default: ; // drop writes to unknown indexes
            endcase
        end
    end

    // Hold off every sample whenever the queue is full, as a group end could not be queued
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    tacr_front #(
        .AVG_SHIFT (AVG_SHIFT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .sample     (s_sample),
        .cfg        (front_cfg_reg),
        .push       (push),
        .push_entry (push_entry)
    );

    tacr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    tacr_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (back_cfg_reg),
        .q_valid    (q_valid),
        .q_entry    (q_head),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_is_touch (m_is_touch),
        .m_x_pos    (m_x_pos),
        .m_y_pos    (m_y_pos)
    );

endmodule

[bench/tb_top.sv]
// Self-checking bench for touch_average_calibrate_rotate: random and directed sample
// streams, an in-order predictor of averaging, calibration and rotation.
// Depends on tacr_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top;

    localparam int          GROUP_LEN      = 16;       // samples per axis group
    localparam int          AVG_BITS       = 4;        // log2 of GROUP_LEN
    localparam logic [15:0] SCREEN_W       = 16'd240;
    localparam logic [15:0] SCREEN_H       = 16'd320;
    localparam int          RESULT_LATENCY = 4;
    localparam int          PHASE_COUNT    = 9;
    localparam int          PHASE_SAMPLES  = 130;      // rough beat budget per config phase
    localparam int          CYCLE_LIMIT    = 400000;
    localparam logic [2:0]  REG_UNUSED     = 3'd7;     // no register lives here

    typedef struct {
        logic        touch;
        logic [15:0] x;
        logic [15:0] y;
    } reading_t;

    // DUT ports; the ones the bench drives are known from time zero
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [15:0] s_sample  = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic        m_is_touch;
    logic [15:0] m_x_pos;
    logic [15:0] m_y_pos;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_addr  = '0;
    logic [15:0] cfg_data  = '0;

    // Bench-side copy of the configuration registers, at their reset values
    logic        [15:0] prs_thr    = '0;
    logic        [15:0] x_thr      = '0;
    logic signed [15:0] gain_x     = tacr_pkg::GAIN_UNITY;
    logic signed [15:0] offset_x   = '0;
    logic signed [15:0] gain_y     = tacr_pkg::GAIN_UNITY;
    logic signed [15:0] offset_y   = '0;
    logic        [1:0]  screen_rot = tacr_pkg::ROT_0;

    // Measurement progress as the block should see it
    tacr_pkg::phase_t meas_phase = tacr_pkg::PH_Z;
    int          group_fill = 0;
    logic [19:0] group_sum  = '0;
    logic [15:0] held_x     = '0;

    logic [15:0] sample_backlog[$];      // beats waiting for the driver
    reading_t    expected_readings[$];   // readings predicted but not yet seen

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;
    int cycle_count   = 0;
    int items_queued  = 0;

    touch_average_calibrate_rotate #(
        .AVG_SHIFT    (AVG_BITS),
        .SCREEN_WIDTH (240),
        .SCREEN_HEIGHT(320)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_is_touch(m_is_touch),
        .m_x_pos   (m_x_pos),
        .m_y_pos   (m_y_pos),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Q2.14 gain times average, floored, plus offset; keep the low 16 bits
    function automatic logic [15:0] apply_gain(input logic signed [15:0] gain,
                                               input logic signed [15:0] offset,
                                               input logic [15:0] avg);
        longint acc;
        acc = longint'(gain) * longint'({1'b0, avg});
        acc = (acc >>> 14) + longint'(offset);
        return acc[15:0];
    endfunction

    function automatic void restart_measurement();
        meas_phase = tacr_pkg::PH_Z;
        group_fill = 0;
        group_sum  = '0;
    endfunction

    // Advance the predicted measurement by one accepted sample; queue a reading
    // when a group closes with a result.
    function automatic void absorb_sample(input logic [15:0] smp);
        logic [15:0] avg;
        logic [15:0] cal_y;
        reading_t    rd;
        if (meas_phase != tacr_pkg::PH_Z && meas_phase != tacr_pkg::PH_X &&
            meas_phase != tacr_pkg::PH_Y)
            restart_measurement();
        group_sum  = group_sum + 20'(smp);
        group_fill = group_fill + 1;
        if (group_fill < GROUP_LEN)
            return;
        avg        = 16'(group_sum >> AVG_BITS);
        group_fill = 0;
        group_sum  = '0;
        rd         = '{1'b0, 16'h0000, 16'h0000};
        case (meas_phase)
            tacr_pkg::PH_Z: begin
                if (avg <= prs_thr) begin
                    restart_measurement();
                    expected_readings.push_back(rd);
                end else begin
                    meas_phase = tacr_pkg::PH_X;
                end
            end
            tacr_pkg::PH_X: begin
                if (avg <= x_thr) begin
                    restart_measurement();
                    expected_readings.push_back(rd);
                end else begin
                    held_x     = apply_gain(gain_x, offset_x, avg);
                    meas_phase = tacr_pkg::PH_Y;
                end
            end
            default: begin
                cal_y    = apply_gain(gain_y, offset_y, avg);
                rd.touch = 1'b1;
                case (screen_rot)
                    tacr_pkg::ROT_0: begin
                        rd.x = held_x;
                        rd.y = cal_y;
                    end
                    tacr_pkg::ROT_90: begin
                        rd.x = cal_y;
                        rd.y = SCREEN_W - held_x;
                    end
                    tacr_pkg::ROT_180: begin
                        rd.x = SCREEN_W - held_x;
                        rd.y = SCREEN_H - cal_y;
                    end
                    default: begin
                        rd.x = SCREEN_H - cal_y;
                        rd.y = held_x;
                    end
                endcase
                restart_measurement();
                expected_readings.push_back(rd);
            end
        endcase
    endfunction

    function automatic void apply_register(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            tacr_pkg::REG_PRESSURE_THRESHOLD: prs_thr    = data;
            tacr_pkg::REG_X_LEVEL_MIN:        x_thr      = data;
            tacr_pkg::REG_X_GAIN:             gain_x     = data;
            tacr_pkg::REG_X_OFFSET:           offset_x   = data;
            tacr_pkg::REG_Y_GAIN:             gain_y     = data;
            tacr_pkg::REG_Y_OFFSET:           offset_y   = data;
            tacr_pkg::REG_ORIENTATION:        screen_rot = data[1:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: %s mismatch, got 0x%04h, want 0x%04h", $time, field, got, want);
        mismatches++;
    endtask

    // One register beat; the shadow copy changes only once the beat is taken
    task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_register(idx, data);
    endtask

    // Hold until every queued beat is taken and every reading is back, then
    // let the pipe run dry.
    task automatic settle();
        do @(posedge aclk);
        while (sample_backlog.size() != 0 || s_valid || expected_readings.size() != 0);
        repeat (RESULT_LATENCY + 4) @(posedge aclk);
    endtask

    // Aim a group average at, just above or on either side of a threshold
    function automatic logic [15:0] pick_level(input logic [15:0] thr);
        case ($urandom_range(0, 9))
            0:       return thr;
            1:       return (thr == 16'hFFFF) ? thr : thr + 16'd1;
            2:       return 16'($urandom_range(0, thr));
            default: return (thr == 16'hFFFF) ? thr : 16'($urandom_range(int'(thr) + 1, 65535));
        endcase
    endfunction

    // Queue one group of samples whose average lands on level (plus a small
    // remainder below the shift), or pure noise; report the average it gives.
    task automatic queue_group(input logic [15:0] level, input bit noisy,
                               output logic [15:0] avg);
        int unsigned total;
        int unsigned spread;
        int unsigned room;
        int unsigned d;
        int unsigned lo;
        int unsigned extra;
        logic [15:0] hi;
        total = 0;
        case ($urandom_range(0, 3))
            0:       spread = 0;
            1:       spread = 15;
            2:       spread = 255;
            default: spread = 65535;
        endcase
        for (int j = 0; j < GROUP_LEN / 2; j++) begin
            if (noisy) begin
                hi = 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
                lo = $urandom_range(0, 65535) >> $urandom_range(0, 15);
            end else begin
                room = (level < 16'hFFFF - level) ? level : 16'hFFFF - level;
                if (room > spread)
                    room = spread;
                d  = $urandom_range(0, room);
                hi = 16'(level + d);
                lo = level - d;
                if (j == GROUP_LEN / 2 - 1) begin
                    extra = $urandom_range(0, 15);
                    lo    = lo + ((extra < 65535 - lo) ? extra : 65535 - lo);
                end
            end
            sample_backlog.push_back(hi);
            sample_backlog.push_back(16'(lo));
            total += hi + lo;
        end
        items_queued += GROUP_LEN;
        avg = 16'(total >> AVG_BITS);
    endtask

    // One pressure / X / Y measurement, stopping where the block would stop
    task automatic queue_measurement();
        logic [15:0] avg;
        logic [15:0] y_level;
        queue_group(pick_level(prs_thr), $urandom_range(0, 99) < 15, avg);
        if (avg <= prs_thr)
            return;
        queue_group(pick_level(x_thr), $urandom_range(0, 99) < 15, avg);
        if (avg <= x_thr)
            return;
        case ($urandom_range(0, 7))
            0:       y_level = 16'h0000;
            1:       y_level = 16'hFFFF;
            default: y_level = 16'($urandom_range(0, 65535));
        endcase
        queue_group(y_level, $urandom_range(0, 99) < 15, avg);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return tacr_pkg::GAIN_UNITY;
            1:       return 16'h0000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Reprogram every register between measurements; phase 1 and 2 pin the
    // calibration extremes, 3 and 4 the threshold extremes.
    task automatic program_phase(input int p);
        logic [15:0] thr_p;
        logic [15:0] thr_x;
        thr_p = 16'($urandom_range(0, 65535));
        thr_x = 16'($urandom_range(0, 65535));
        if (p == 1 || p == 3)
            thr_p = 16'h0000;
        if (p == 4)
            thr_p = 16'hFFFF;
        if (p == 1)
            thr_x = 16'h0000;
        if (p == 3)
            thr_x = 16'hFFFF;
        write_register(tacr_pkg::REG_PRESSURE_THRESHOLD, thr_p);
        write_register(tacr_pkg::REG_X_LEVEL_MIN, thr_x);
        if (p == 1) begin
            write_register(tacr_pkg::REG_X_GAIN, 16'h7FFF);
            write_register(tacr_pkg::REG_X_OFFSET, 16'h7FFF);
            write_register(tacr_pkg::REG_Y_GAIN, 16'h7FFF);
            write_register(tacr_pkg::REG_Y_OFFSET, 16'h7FFF);
        end else if (p == 2) begin
            write_register(tacr_pkg::REG_X_GAIN, 16'h8000);
            write_register(tacr_pkg::REG_X_OFFSET, 16'h8000);
            write_register(tacr_pkg::REG_Y_GAIN, 16'h8000);
            write_register(tacr_pkg::REG_Y_OFFSET, 16'h8000);
        end else begin
            write_register(tacr_pkg::REG_X_GAIN, pick_gain());
            write_register(tacr_pkg::REG_X_OFFSET, 16'($urandom_range(0, 65535)));
            write_register(tacr_pkg::REG_Y_GAIN, pick_gain());
            write_register(tacr_pkg::REG_Y_OFFSET, 16'($urandom_range(0, 65535)));
        end
        // upper data bits are junk the block must drop
        write_register(tacr_pkg::REG_ORIENTATION, {14'($urandom), 2'(p % 4)});
        write_register(REG_UNUSED, 16'($urandom_range(0, 65535)));
    endtask

    // Input driver: advance on acceptance, idle at random between beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                absorb_sample(s_sample);
            if (!s_valid || s_ready) begin
                if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid  <= 1'b1;
                    s_sample <= sample_backlog.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: stall at random, check each reading against the oldest one due
    always @(posedge aclk) begin : result_monitor
        reading_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    $display("%0t: reading with none due (touch %0b x 0x%04h y 0x%04h)",
                             $time, m_is_touch, m_x_pos, m_y_pos);
                    mismatches++;
                end else begin
                    want = expected_readings.pop_front();
                    if (m_is_touch !== want.touch)
                        report_mismatch("is_touch", 16'(m_is_touch), 16'(want.touch));
                    if (m_x_pos !== want.x)
                        report_mismatch("x_pos", m_x_pos, want.x);
                    if (m_y_pos !== want.y)
                        report_mismatch("y_pos", m_y_pos, want.y);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        int phase_start;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p != 0) begin
                settle();
                program_phase(p);
            end
            // sender rarely idles while the receiver stalls hard, then swap, then run flat out
            if (p < PHASE_COUNT / 3) begin
                send_idle_pct = 6;
                recv_idle_pct = 80;
            end else if (p < 2 * PHASE_COUNT / 3) begin
                send_idle_pct = 80;
                recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 0) begin
                // full-scale pressure and X, Y swinging rail to rail: a touch at reset settings
                for (int i = 0; i < 2 * GROUP_LEN; i++)
                    sample_backlog.push_back(16'hFFFF);
                for (int i = 0; i < GROUP_LEN; i++)
                    sample_backlog.push_back(i[0] ? 16'hFFFF : 16'h0000);
                items_queued += 3 * GROUP_LEN;
            end
            phase_start = items_queued;
            while (items_queued - phase_start < PHASE_SAMPLES)
                queue_measurement();
        end

        settle();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
rtl/core/tacr_pkg.sv
rtl/core/tacr_front.sv
rtl/core/tacr_queue.sv
rtl/core/tacr_back.sv
rtl/core/touch_average_calibrate_rotate.sv
bench/tb_top.sv
